@@ sv/acsl_pkg.sv @@
// shared types and constants of the arm and collision speed limit block
`timescale 1ns / 1ps
package acsl_pkg;

	localparam int unsigned QW = 16;
	localparam logic [QW-1:0] ONE_Q15 = 16'd32768;

	// commands
	localparam logic [1:0] CMD_ARM    = 2'd0;
	localparam logic [1:0] CMD_DISARM = 2'd1;
	localparam logic [1:0] CMD_LIMIT  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_ARM_ZERO_COUNT = 3'd0;
	localparam logic [2:0] REG_COLLISION_EN   = 3'd1;
	localparam logic [2:0] REG_IGNORE_FRONT   = 3'd2;
	localparam logic [2:0] REG_SLOW_FACTOR    = 3'd3;
	localparam logic [2:0] REG_CRAWL_FACTOR   = 3'd4;
	localparam logic [2:0] REG_RELEASE_MS     = 3'd5;

	// register reset values
	localparam logic [15:0] RST_ARM_ZERO_COUNT = 16'd20;
	localparam logic [15:0] RST_SLOW_FACTOR    = 16'd16384;
	localparam logic [15:0] RST_CRAWL_FACTOR   = 16'd8192;
	localparam logic [15:0] RST_RELEASE_MS     = 16'd1000;

	// zone codes
	localparam logic [1:0] PROX_CLEAR = 2'd0;
	localparam logic [1:0] PROX_SLOW  = 2'd1;
	localparam logic [1:0] PROX_CRAWL = 2'd2;
	localparam logic [1:0] PROX_STOP  = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic               joystick_valid;
		logic signed [15:0] wheel_a;
		logic signed [15:0] wheel_b;
		logic signed [15:0] wheel_c;
		logic signed [15:0] wheel_d;
		logic [15:0]        elapsed_ms;
		logic [13:0]        zone_codes;
		logic [15:0]        lidar_front_factor;
		logic signed [15:0] drive_x;
		logic signed [15:0] drive_y;
		logic signed [15:0] drive_rotation;
	} in_item_t;

	typedef struct packed {
		logic               motors_armed;
		logic signed [15:0] limited_x;
		logic signed [15:0] limited_y;
		logic signed [15:0] limited_rotation;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [15:0] data;
	} cfg_item_t;

endpackage

@@ sv/acsl_stream_if.sv @@
// valid/ready channel carrying one payload of a given type
`timescale 1ns / 1ps
interface acsl_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/arm_and_collision_speed_limit_unit.sv @@
// arm and collision speed limit unit: arming sequencer, limit easing and drive scaling
`timescale 1ns / 1ps
// Arming and disarm requests, and limit requests while the motors are disarmed or
// collision handling is off, finish in the cycle they are accepted: the result is
// offered on the next cycle. A limit request with collision handling active runs
// through a shared restoring divider for the easing step (skipped when
// elapsed_ms >= release_ms or release_ms is 0), an easing state, and a shared
// 16x16 multiplier that scales the three axes in turn, each in a multiply state
// and a write-back state, then a final state that loads the result once the output
// is free. in_ch.ready is low while a request is worked on
// or while a finished result still waits to be taken. The configuration port is
// always ready; its registers are to be written only while the unit is idle.
module arm_and_collision_speed_limit_unit (
	input logic clk,
	input logic arst_n,
	acsl_stream_if.sink   in_ch,
	acsl_stream_if.source out_ch,
	acsl_stream_if.sink   cfg_ch
);
	import acsl_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_EASE = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_WB   = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	localparam logic [1:0] AX_X   = 2'd0;
	localparam logic [1:0] AX_Y   = 2'd1;
	localparam logic [1:0] AX_ROT = 2'd2;

	localparam logic [3:0] DIV_LAST = 4'd14;

	// configuration
	logic [15:0] arm_zero_count_q, slow_factor_q, crawl_factor_q, release_ms_q;
	logic        collision_enable_q, ignore_front_q;

	// block state
	logic        armed_q;
	logic [15:0] zero_run_q;
	logic [15:0] front_lim_q, back_lim_q, left_lim_q, right_lim_q, turn_lim_q;

	// sequencer and datapath
	logic [2:0]  state_q;
	logic [3:0]  cnt_q;
	logic [1:0]  axis_q;
	logic [15:0] rem_q;
	logic [13:0] quo_q;
	logic [15:0] step_q;
	logic [15:0] tgt_front_q, tgt_back_q, tgt_left_q, tgt_right_q, tgt_turn_q;
	logic signed [15:0] dx_q, dy_q, dr_q;
	logic signed [15:0] lx_q, ly_q, lr_q;
	logic [31:0] prod_q;
	logic        neg_q;

	logic        out_valid_q;
	out_item_t   out_q;

	in_item_t    req;
	cfg_item_t   wr;
	logic        in_acc, out_free, limits_active, out_load;

	function automatic logic [15:0] sat_one(input logic [15:0] f);
		sat_one = (f > ONE_Q15) ? ONE_Q15 : f;
	endfunction

	function automatic logic [15:0] zone_factor(input logic [1:0] z, input logic [15:0] slow,
			input logic [15:0] crawl);
		case (z)
			PROX_CLEAR: zone_factor = ONE_Q15;
			PROX_SLOW:  zone_factor = sat_one(slow);
			PROX_CRAWL: zone_factor = sat_one(crawl);
			PROX_STOP:  zone_factor = 16'd0;
			default:    zone_factor = ONE_Q15;
		endcase
	endfunction

	function automatic logic [1:0] worse(input logic [1:0] a, input logic [1:0] b);
		worse = (a > b) ? a : b;
	endfunction

	function automatic logic [15:0] ease(input logic [15:0] lim, input logic [15:0] tgt,
			input logic [15:0] step);
		logic [16:0] sum;
		sum = {1'b0, lim} + {1'b0, step};
		if (tgt < lim) begin
			ease = tgt;
		end else if (sum < {1'b0, tgt}) begin
			ease = sum[15:0];
		end else begin
			ease = tgt;
		end
	endfunction

	assign req = in_ch.payload;
	assign wr  = cfg_ch.payload;

	assign out_free      = !out_valid_q || out_ch.ready;
	assign in_ch.ready   = (state_q == ST_IDLE) && out_free;
	assign in_acc        = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready  = 1'b1;
	assign out_ch.valid  = out_valid_q;
	assign out_ch.payload = out_q;
	assign limits_active = armed_q && collision_enable_q;

	// a result is loaded straight from the request or at the end of a limit run
	assign out_load = ((state_q == ST_IDLE) && in_acc &&
		!(req.cmd == CMD_LIMIT && limits_active)) || ((state_q == ST_FIN) && out_free);

	// arming decision for an arm check request
	logic        wheels_zero;
	logic [15:0] run_inc;
	logic        arm_now;
	logic        armed_d;
	logic [15:0] zero_run_d;

	assign wheels_zero = (req.wheel_a == 16'sd0) && (req.wheel_b == 16'sd0) &&
		(req.wheel_c == 16'sd0) && (req.wheel_d == 16'sd0);
	assign run_inc = (zero_run_q == 16'hFFFF) ? zero_run_q : zero_run_q + 16'd1;

	always_comb begin
		armed_d    = armed_q;
		zero_run_d = zero_run_q;
		arm_now    = 1'b0;
		case (req.cmd)
			CMD_ARM: begin
				if (!req.joystick_valid) begin
					armed_d    = 1'b0;
					zero_run_d = 16'd0;
				end else if (!armed_q) begin
					zero_run_d = wheels_zero ? run_inc : 16'd0;
					arm_now    = zero_run_d > arm_zero_count_q;
					if (arm_now) begin
						armed_d    = 1'b1;
						zero_run_d = 16'd0;
					end
				end
			end
			CMD_DISARM: begin
				armed_d    = 1'b0;
				zero_run_d = 16'd0;
			end
			default: begin
			end
		endcase
	end

	// per-direction targets from the zone codes
	logic [1:0]  s_fl, s_fr, s_bk, s_sl, s_sr, l_fl, l_fr, s_front, worst;
	logic [15:0] lidar_f, front_sensor_f, front_t, turn_t;

	always_comb begin
		s_fl = req.zone_codes[1:0];
		s_fr = req.zone_codes[3:2];
		s_bk = req.zone_codes[5:4];
		s_sl = req.zone_codes[7:6];
		s_sr = req.zone_codes[9:8];
		l_fl = req.zone_codes[11:10];
		l_fr = req.zone_codes[13:12];
		lidar_f        = sat_one(req.lidar_front_factor);
		s_front        = worse(s_fl, s_fr);
		front_sensor_f = zone_factor(s_front, slow_factor_q, crawl_factor_q);
		front_t = lidar_f;
		worst   = worse(l_fl, l_fr);
		if (!ignore_front_q) begin
			if (front_sensor_f < front_t) begin
				front_t = front_sensor_f;
			end
			worst = worse(worst, s_front);
		end
		worst  = worse(worst, worse(s_bk, worse(s_sl, s_sr)));
		turn_t = (worst >= PROX_CRAWL) ? sat_one(crawl_factor_q) : ONE_Q15;
	end

	// shared divider step and shared multiplier operands
	logic [16:0] trial;
	logic        qbit;
	logic [15:0] rem_d;
	logic signed [15:0] mul_v;
	logic [15:0] mul_lim, mul_mag;
	logic [15:0] scaled;
	logic signed [15:0] scaled_s;

	assign trial = {rem_q, 1'b0};
	assign qbit  = trial >= {1'b0, release_ms_q};
	assign rem_d = qbit ? 16'(trial - {1'b0, release_ms_q}) : trial[15:0];

	always_comb begin
		case (axis_q)
			AX_X: begin
				mul_v   = dx_q;
				mul_lim = (dx_q > 16'sd0) ? right_lim_q : left_lim_q;
			end
			AX_Y: begin
				mul_v   = dy_q;
				mul_lim = (dy_q > 16'sd0) ? front_lim_q : back_lim_q;
			end
			default: begin
				mul_v   = dr_q;
				mul_lim = turn_lim_q;
			end
		endcase
		mul_mag = mul_v[15] ? 16'(~mul_v + 16'sd1) : mul_v;
	end

	assign scaled   = prod_q[30:15];
	assign scaled_s = neg_q ? 16'(-$signed(scaled)) : $signed(scaled);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_zero_count_q   <= RST_ARM_ZERO_COUNT;
			collision_enable_q <= 1'b1;
			ignore_front_q     <= 1'b0;
			slow_factor_q      <= RST_SLOW_FACTOR;
			crawl_factor_q     <= RST_CRAWL_FACTOR;
			release_ms_q       <= RST_RELEASE_MS;
		end else if (cfg_ch.valid) begin
			case (wr.index)
				REG_ARM_ZERO_COUNT: arm_zero_count_q   <= wr.data;
				REG_COLLISION_EN:   collision_enable_q <= wr.data[0];
				REG_IGNORE_FRONT:   ignore_front_q     <= wr.data[0];
				REG_SLOW_FACTOR:    slow_factor_q      <= wr.data;
				REG_CRAWL_FACTOR:   crawl_factor_q     <= wr.data;
				REG_RELEASE_MS:     release_ms_q       <= wr.data;
				default: begin
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			armed_q     <= 1'b0;
			zero_run_q  <= 16'd0;
			front_lim_q <= ONE_Q15;
			back_lim_q  <= ONE_Q15;
			left_lim_q  <= ONE_Q15;
			right_lim_q <= ONE_Q15;
			turn_lim_q  <= ONE_Q15;
			cnt_q       <= 4'd0;
			axis_q      <= AX_X;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						armed_q    <= armed_d;
						zero_run_q <= zero_run_d;
						if (req.cmd == CMD_LIMIT && limits_active) begin
							cnt_q  <= 4'd0;
							axis_q <= AX_X;
							if (release_ms_q == 16'd0 || req.elapsed_ms >= release_ms_q) begin
								state_q <= ST_EASE;
							end else begin
								state_q <= ST_DIV;
							end
						end else if (req.cmd == CMD_LIMIT) begin
							front_lim_q <= ONE_Q15;
							back_lim_q  <= ONE_Q15;
							left_lim_q  <= ONE_Q15;
							right_lim_q <= ONE_Q15;
							turn_lim_q  <= ONE_Q15;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_EASE;
					end
				end
				ST_EASE: begin
					front_lim_q <= ease(front_lim_q, tgt_front_q, step_q);
					back_lim_q  <= ease(back_lim_q, tgt_back_q, step_q);
					left_lim_q  <= ease(left_lim_q, tgt_left_q, step_q);
					right_lim_q <= ease(right_lim_q, tgt_right_q, step_q);
					turn_lim_q  <= ease(turn_lim_q, tgt_turn_q, step_q);
					state_q     <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (axis_q == AX_ROT) begin
						state_q <= ST_FIN;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					rem_q       <= req.elapsed_ms;
					quo_q       <= 14'd0;
					step_q      <= ONE_Q15;
					tgt_front_q <= front_t;
					tgt_back_q  <= zone_factor(s_bk, slow_factor_q, crawl_factor_q);
					tgt_left_q  <= zone_factor(s_sl, slow_factor_q, crawl_factor_q);
					tgt_right_q <= zone_factor(s_sr, slow_factor_q, crawl_factor_q);
					tgt_turn_q  <= turn_t;
					dx_q        <= req.drive_x;
					dy_q        <= req.drive_y;
					dr_q        <= req.drive_rotation;
					out_q.motors_armed <= armed_d;
					if (req.cmd == CMD_LIMIT) begin
						// pass-through when limits are inactive
						out_q.limited_x        <= req.drive_x;
						out_q.limited_y        <= req.drive_y;
						out_q.limited_rotation <= req.drive_rotation;
					end else begin
						out_q.limited_x        <= 16'sd0;
						out_q.limited_y        <= 16'sd0;
						out_q.limited_rotation <= 16'sd0;
					end
				end
			end
			ST_DIV: begin
				rem_q <= rem_d;
				quo_q <= {quo_q[12:0], qbit};
				if (cnt_q == DIV_LAST) begin
					step_q <= {1'b0, quo_q, qbit};
				end
			end
			ST_MUL: begin
				prod_q <= mul_mag * mul_lim;
				neg_q  <= mul_v[15];
			end
			ST_WB: begin
				case (axis_q)
					AX_X:    lx_q <= scaled_s;
					AX_Y:    ly_q <= scaled_s;
					default: lr_q <= scaled_s;
				endcase
			end
			ST_FIN: begin
				if (out_free) begin
					out_q.motors_armed     <= armed_q;
					out_q.limited_x        <= lx_q;
					out_q.limited_y        <= ly_q;
					out_q.limited_rotation <= lr_q;
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready)
		else $error("request taken while a limit request is in progress");

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < release_ms_q))
		else $error("divider remainder not below release time");

	a_limit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(front_lim_q <= ONE_Q15) && (back_lim_q <= ONE_Q15) && (left_lim_q <= ONE_Q15) &&
		(right_lim_q <= ONE_Q15) && (turn_lim_q <= ONE_Q15))
		else $error("speed limit above 1.0");

	a_disarm: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req.cmd == CMD_DISARM) |=> (!armed_q && zero_run_q == 16'd0))
		else $error("disarm request left motors armed");

	a_inactive_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req.cmd == CMD_LIMIT && !limits_active) |=>
		(front_lim_q == ONE_Q15 && turn_lim_q == ONE_Q15 && out_valid_q))
		else $error("inactive limit request did not restore limits");

endmodule

@@ bench/arm_and_collision_speed_limit_unit_test.sv @@
// self-checking bench for the arm and collision speed limit unit
`timescale 1ns / 1ps
module arm_and_collision_speed_limit_unit_test;
	import acsl_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned FULL = 32'(ONE_Q15);
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned RUN_CEILING = 65535;

	logic clk;
	logic arst_n;

	acsl_stream_if #(.payload_t(in_item_t))  in_ch ();
	acsl_stream_if #(.payload_t(out_item_t)) out_ch ();
	acsl_stream_if #(.payload_t(cfg_item_t)) cfg_ch ();

	arm_and_collision_speed_limit_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// register copies
	int unsigned arm_count_r = 32'(RST_ARM_ZERO_COUNT);
	bit          coll_en_r   = 1'b1;
	bit          ign_front_r = 1'b0;
	int unsigned slow_r      = 32'(RST_SLOW_FACTOR);
	int unsigned crawl_r     = 32'(RST_CRAWL_FACTOR);
	int unsigned release_r   = 32'(RST_RELEASE_MS);

	// safety state copies
	bit          armed_m    = 1'b0;
	int unsigned zero_run_m = 0;
	int unsigned front_lim  = FULL;
	int unsigned back_lim   = FULL;
	int unsigned left_lim   = FULL;
	int unsigned right_lim  = FULL;
	int unsigned turn_lim   = FULL;

	in_item_t  request_queue [$];
	out_item_t awaited_results [$];
	int        fault_count = 0;
	int unsigned cycle_count = 0;

	int src_gap = 0;
	int src_stretch = 0;
	bit src_quiet = 1'b0;
	int snk_hold = 0;
	int snk_stretch = 0;
	bit snk_quiet = 1'b0;

	function automatic int unsigned capped(int unsigned f);
		return (f > FULL) ? FULL : f;
	endfunction

	function automatic int unsigned zone_gain(logic [1:0] z);
		case (z)
		PROX_SLOW:  return capped(slow_r);
		PROX_CRAWL: return capped(crawl_r);
		PROX_STOP:  return 0;
		default:    return FULL;
		endcase
	endfunction

	function automatic logic [1:0] graver(logic [1:0] a, logic [1:0] b);
		return (a > b) ? a : b;
	endfunction

	// stricter target at once, looser one by at most a step
	function automatic int unsigned eased(int unsigned lim, int unsigned target,
			int unsigned stp);
		if (target < lim)
			return target;
		return (lim + stp < target) ? lim + stp : target;
	endfunction

	function automatic logic signed [15:0] scaled(logic signed [15:0] v, int unsigned lim);
		longint mag;
		mag = longint'(v);
		if (mag < 0)
			mag = -mag;
		mag = (mag * longint'(lim)) >> 15;
		if (v < 0)
			mag = -mag;
		return mag[15:0];
	endfunction

	function automatic out_item_t limited_drive_of(in_item_t it);
		out_item_t res;
		longint unsigned quot;
		int unsigned stp;
		int unsigned front_t;
		logic [1:0] sf;
		logic [1:0] worst;
		logic [13:0] zc;
		res = '0;
		zc = it.zone_codes;
		case (it.cmd)
		CMD_ARM: begin
			if (!it.joystick_valid) begin
				armed_m = 1'b0;
				zero_run_m = 0;
			end else if (!armed_m) begin
				if (it.wheel_a == 0 && it.wheel_b == 0 && it.wheel_c == 0 && it.wheel_d == 0) begin
					if (zero_run_m < RUN_CEILING)
						zero_run_m++;
				end else begin
					zero_run_m = 0;
				end
				if (zero_run_m > arm_count_r) begin
					armed_m = 1'b1;
					zero_run_m = 0;
				end
			end
		end
		CMD_DISARM: begin
			armed_m = 1'b0;
			zero_run_m = 0;
		end
		CMD_LIMIT: begin
			if (release_r == 0) begin
				stp = FULL;
			end else begin
				quot = 64'(it.elapsed_ms);
				quot = (quot << 15) / 64'(release_r);
				stp = (quot > 64'(FULL)) ? FULL : quot[31:0];
			end
			if (!armed_m || !coll_en_r) begin
				front_lim = FULL;
				back_lim = FULL;
				left_lim = FULL;
				right_lim = FULL;
				turn_lim = FULL;
				res.limited_x = it.drive_x;
				res.limited_y = it.drive_y;
				res.limited_rotation = it.drive_rotation;
			end else begin
				sf = graver(zc[1:0], zc[3:2]);
				worst = graver(zc[11:10], zc[13:12]);
				front_t = capped(32'(it.lidar_front_factor));
				if (!ign_front_r) begin
					if (zone_gain(sf) < front_t)
						front_t = zone_gain(sf);
					worst = graver(worst, sf);
				end
				worst = graver(worst, graver(zc[5:4], graver(zc[7:6], zc[9:8])));
				front_lim = eased(front_lim, front_t, stp);
				back_lim = eased(back_lim, zone_gain(zc[5:4]), stp);
				right_lim = eased(right_lim, zone_gain(zc[9:8]), stp);
				left_lim = eased(left_lim, zone_gain(zc[7:6]), stp);
				turn_lim = eased(turn_lim, (worst >= PROX_CRAWL) ? capped(crawl_r) : FULL, stp);
				// a zero axis scales to zero on either side
				res.limited_y = (it.drive_y > 0) ? scaled(it.drive_y, front_lim)
					: scaled(it.drive_y, back_lim);
				res.limited_x = (it.drive_x > 0) ? scaled(it.drive_x, right_lim)
					: scaled(it.drive_x, left_lim);
				res.limited_rotation = scaled(it.drive_rotation, turn_lim);
			end
		end
		default: ;
		endcase
		res.motors_armed = armed_m;
		return res;
	endfunction

	function automatic void take_setting(logic [2:0] idx, logic [15:0] val);
		case (idx)
		REG_ARM_ZERO_COUNT: arm_count_r = 32'(val);
		REG_COLLISION_EN:   coll_en_r = val[0];
		REG_IGNORE_FRONT:   ign_front_r = val[0];
		REG_SLOW_FACTOR:    slow_r = 32'(val);
		REG_CRAWL_FACTOR:   crawl_r = 32'(val);
		REG_RELEASE_MS:     release_r = 32'(val);
		default: ;
		endcase
	endfunction

	// idle draw: stretches with no idling are mixed at random with stretches of random waits
	function automatic int draw_wait(ref int stretch, ref bit quiet);
		if (stretch == 0) begin
			stretch = int'($urandom_range(8, 40));
			quiet = ($urandom_range(0, 2) == 0);
		end
		stretch--;
		return quiet ? 0 : int'($urandom_range(0, 12));
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				awaited_results.push_back(limited_drive_of(in_ch.payload));
			if (!in_ch.valid || in_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					in_ch.valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					in_ch.payload <= request_queue.pop_front();
					in_ch.valid <= 1'b1;
					src_gap = draw_wait(src_stretch, src_quiet);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and sink stalls
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.payload;
				if (awaited_results.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unrequested result: armed %0d x %0d y %0d rot %0d",
							got.motors_armed, got.limited_x, got.limited_y,
							got.limited_rotation);
				end else begin
					want = awaited_results.pop_front();
					if (got.motors_armed !== want.motors_armed ||
							got.limited_x !== want.limited_x ||
							got.limited_y !== want.limited_y ||
							got.limited_rotation !== want.limited_rotation) begin
						fault_count++;
						if (fault_count <= 10)
							$display("mismatch: expected armed %0d x %0d y %0d rot %0d,",
								want.motors_armed, want.limited_x, want.limited_y,
								want.limited_rotation,
								" got armed %0d x %0d y %0d rot %0d",
								got.motors_armed, got.limited_x,
								got.limited_y, got.limited_rotation);
					end
				end
				snk_hold = draw_wait(snk_stretch, snk_quiet);
			end else if (out_ch.valid && snk_hold > 0) begin
				snk_hold--;
			end
			out_ch.ready <= (snk_hold == 0);
		end
	end

	// register write; valid stays high so writes can follow back to back
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_ch.payload <= '{index: idx, data: val};
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		take_setting(idx, val);
	endtask

	task automatic write_settings(input logic [15:0] azc, input logic [15:0] coll,
			input logic [15:0] ign, input logic [15:0] slow, input logic [15:0] crawl,
			input logic [15:0] rel);
		write_reg(REG_ARM_ZERO_COUNT, azc);
		write_reg(REG_COLLISION_EN, coll);
		write_reg(REG_IGNORE_FRONT, ign);
		write_reg(REG_SLOW_FACTOR, slow);
		write_reg(REG_CRAWL_FACTOR, crawl);
		write_reg(REG_RELEASE_MS, rel);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (request_queue.size() != 0 || in_ch.valid || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] drive_value();
		case ($urandom_range(0, 7))
		0: return 16'h8000;
		1: return 16'h7FFF;
		2: return 16'($urandom_range(0, 3)) - 16'd1;
		3: return 16'($urandom_range(0, 2000)) - 16'd1000;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t random_fields();
		in_item_t it;
		it.cmd = 2'($urandom);
		it.joystick_valid = 1'($urandom);
		it.wheel_a = 16'($urandom);
		it.wheel_b = 16'($urandom);
		it.wheel_c = 16'($urandom);
		it.wheel_d = 16'($urandom);
		it.elapsed_ms = 16'($urandom);
		it.zone_codes = 14'($urandom);
		it.lidar_front_factor = 16'($urandom);
		it.drive_x = drive_value();
		it.drive_y = drive_value();
		it.drive_rotation = drive_value();
		return it;
	endfunction

	function automatic in_item_t limit_request();
		in_item_t it;
		it = random_fields();
		it.cmd = CMD_LIMIT;
		case ($urandom_range(0, 3))
		0: it.elapsed_ms = 16'($urandom_range(0, 20));
		1: it.elapsed_ms = 16'($urandom_range(0, 400));
		2: it.elapsed_ms = 16'($urandom_range(0, 3000));
		default: ;
		endcase
		// mostly clear zones so the limits get room to ease back
		if ($urandom_range(0, 2) != 0)
			for (int z = 0; z < 7; z++)
				it.zone_codes[2*z +: 2] = ($urandom_range(0, 2) == 0) ?
					2'($urandom) : PROX_CLEAR;
		case ($urandom_range(0, 3))
		0: it.lidar_front_factor = 16'(FULL);
		1: it.lidar_front_factor = 16'($urandom_range(0, FULL));
		2: it.lidar_front_factor = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'd0;
		default: ;
		endcase
		return it;
	endfunction

	// run of zero wheel requests, long enough to arm unless the arming count is above 30, now and then broken
	function automatic int queue_arming();
		in_item_t it;
		int run;
		int spoil;
		run = (arm_count_r > 30) ? 3 : int'(arm_count_r) + 1;
		spoil = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, run - 1)) : -1;
		for (int k = 0; k < run; k++) begin
			it = random_fields();
			it.cmd = CMD_ARM;
			it.joystick_valid = 1'b1;
			it.wheel_a = '0;
			it.wheel_b = '0;
			it.wheel_c = '0;
			it.wheel_d = '0;
			if (k == spoil) begin
				if ($urandom_range(0, 1))
					it.joystick_valid = 1'b0;
				else
					it.wheel_c = 16'd1 << $urandom_range(0, 15);
			end
			request_queue.push_back(it);
		end
		return run;
	endfunction

	task automatic queue_random(input int n);
		in_item_t it;
		int made;
		int pick;
		made = queue_arming();
		while (made < n) begin
			pick = int'($urandom_range(0, 99));
			it = random_fields();
			if (pick < 74) begin
				request_queue.push_back(limit_request());
				made++;
			end else if (pick < 82) begin
				made += queue_arming();
			end else if (pick < 88) begin
				it.cmd = CMD_DISARM;
				request_queue.push_back(it);
				made++;
			end else if (pick < 97) begin
				it.cmd = CMD_ARM;
				it.joystick_valid = ($urandom_range(0, 3) != 0);
				request_queue.push_back(it);
				made++;
			end else begin
				it.cmd = CMD_UNUSED;
				request_queue.push_back(it);
				made++;
			end
		end
	endtask

	task automatic queue_directed();
		in_item_t it;
		// pass-through while disarmed, drive extremes
		it = '0;
		it.cmd = CMD_LIMIT;
		it.zone_codes = '1;
		it.drive_x = 16'h8000;
		it.drive_y = 16'h7FFF;
		it.drive_rotation = 16'hFFFF;
		request_queue.push_back(it);
		// unused command with every bit set
		it = '1;
		it.cmd = CMD_UNUSED;
		request_queue.push_back(it);
		// lost joystick
		it = '0;
		it.cmd = CMD_ARM;
		request_queue.push_back(it);
		// one non-zero wheel restarts the run
		it.joystick_valid = 1'b1;
		it.wheel_d = 16'h8000;
		request_queue.push_back(it);
		// zero request arms at once with a count of zero
		it.wheel_d = '0;
		request_queue.push_back(it);
		// everything in the stop zone
		it = '0;
		it.cmd = CMD_LIMIT;
		it.zone_codes = '1;
		it.drive_x = 16'h8000;
		it.drive_y = 16'h8000;
		it.drive_rotation = 16'h8000;
		request_queue.push_back(it);
		// clear, oversized lidar factor and saturated step
		it.zone_codes = '0;
		it.lidar_front_factor = 16'hFFFF;
		it.elapsed_ms = 16'hFFFF;
		it.drive_x = 16'h7FFF;
		it.drive_y = 16'h8000;
		it.drive_rotation = 16'h7FFF;
		request_queue.push_back(it);
		// slow zones everywhere with slow at full scale
		it.zone_codes = 14'h1555;
		it.lidar_front_factor = 16'(FULL);
		it.elapsed_ms = '0;
		it.drive_x = 16'd1000;
		it.drive_y = -16'sd1000;
		it.drive_rotation = 16'd1000;
		request_queue.push_back(it);
		// crawl zones everywhere with crawl at zero
		it.zone_codes = 14'h2AAA;
		it.drive_y = 16'd1000;
		it.drive_x = -16'sd1000;
		request_queue.push_back(it);
		// clear again but no time has passed
		it.zone_codes = '0;
		it.drive_x = 16'd12345;
		it.drive_y = 16'd12345;
		it.drive_rotation = -16'sd12345;
		request_queue.push_back(it);
		// one millisecond is the whole release time
		it.elapsed_ms = 16'd1;
		request_queue.push_back(it);
		it = '0;
		it.cmd = CMD_DISARM;
		it.joystick_valid = 1'b1;
		request_queue.push_back(it);
		it.cmd = CMD_LIMIT;
		it.zone_codes = '1;
		it.drive_y = -16'sd7;
		request_queue.push_back(it);
		it = '0;
		it.cmd = CMD_ARM;
		it.joystick_valid = 1'b1;
		request_queue.push_back(it);
		// lidar alone limits the front, back stays clear
		it = '0;
		it.cmd = CMD_LIMIT;
		it.lidar_front_factor = 16'd16384;
		it.drive_y = 16'd20000;
		it.drive_x = -16'sd20000;
		request_queue.push_back(it);
		it.drive_y = -16'sd20000;
		it.drive_x = 16'd20000;
		request_queue.push_back(it);
		// worst front sensor beats lidar, ignored later
		it.zone_codes = {2'd0, 2'd0, 2'd0, 2'd0, 2'd0, PROX_STOP, PROX_SLOW};
		it.drive_y = 16'h7FFF;
		request_queue.push_back(it);
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// arm on the first zero request, crawl stops dead, one ms releases fully
		write_settings(16'd0, 16'd1, 16'd0, 16'(FULL), 16'd0, 16'd1);
		queue_directed();
		drain();

		write_settings(RST_ARM_ZERO_COUNT, 16'd1, 16'd0, RST_SLOW_FACTOR,
			RST_CRAWL_FACTOR, RST_RELEASE_MS);
		queue_random(200);
		drain();

		write_settings(16'd3, 16'd1, 16'd1, 16'd0, 16'(FULL), 16'hFFFF);
		queue_random(120);
		drain();

		// oversized factors and zero release time
		write_settings(16'd2, 16'd1, 16'd0, 16'hFFFF, 16'd40000, 16'd0);
		queue_random(150);
		drain();

		// longest arming count, never reached here
		write_settings(16'hFFFF, 16'd1, 16'd0, 16'd20000, 16'd5000, 16'd50);
		queue_random(60);
		drain();

		// collision handling off
		write_settings(16'd1, 16'd0, 16'd0, 16'd16384, 16'd8192, 16'd100);
		queue_random(80);
		drain();

		repeat (4) begin
			write_settings(16'($urandom_range(0, 6)), 16'($urandom_range(0, 5) != 0),
				16'($urandom_range(0, 1)),
				16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, FULL)),
				16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, FULL)),
				16'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 20)
					: (($urandom_range(0, 1) != 0) ? $urandom_range(20, 2000)
					: $urandom_range(0, 65535))));
			queue_random(150);
			drain();
		end

		repeat (40) @(posedge clk);
		if (awaited_results.size() != 0)
			fault_count++;
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
sv/acsl_pkg.sv
sv/acsl_stream_if.sv
sv/arm_and_collision_speed_limit_unit.sv
bench/arm_and_collision_speed_limit_unit_test.sv
